// ----- design/ohlc_pkg.sv -----
// Shared types and constants of the OHLC bid/ask bar aggregator.
package ohlc_pkg;

    localparam int TIME_W     = 63;
    localparam int FIELD_W    = 32;
    localparam int MIN_W      = 11;
    localparam int NUM_PRICES = 8;

    // One minute in nanoseconds.
    localparam logic [35:0] NS_PER_MINUTE = 36'd60000000000;

    // The longest period, 2047 minutes, stays below 2**47 ns.
    localparam int PER_W = 47;
    localparam int CNT_W = $clog2(TIME_W);

    localparam int IN_DATA_W    = 352;
    localparam int OUT_DATA_W   = 384;
    localparam int IN_PRICE_LSB = TIME_W;
    localparam int IN_VOL_LSB   = TIME_W + NUM_PRICES * FIELD_W;

    // Price slots, in the order they travel on the streams.
    localparam int P_BO = 0;
    localparam int P_BC = 1;
    localparam int P_BH = 2;
    localparam int P_BL = 3;
    localparam int P_AO = 4;
    localparam int P_AC = 5;
    localparam int P_AH = 6;
    localparam int P_AL = 7;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PERIOD = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

// ----- design/ohlc_bid_ask_bar_aggregator_top.sv -----
// Top level of the OHLC bid/ask bar aggregator with its modulo sequencer.
//
// The slave stream carries one lower-timeframe bid/ask bar per item: its
// nanosecond timestamp, eight prices and a volume. The master stream returns
// one item per input: the new-bar flag on tuser, and the bar count and the
// held aggregated bar on tdata. The user must write the bar length in minutes
// (cfg_wr_en / cfg_wr_data) only while idle; the block does not enforce it.
//
// An accepted item passes through ST_PERIOD, which forms the period (minutes
// times one minute in ns, zero minutes acting as one), ST_DIV, a radix-2
// restoring remainder unit that brings one timestamp bit per cycle, and
// ST_DONE, which rounds the timestamp down and merges the item into the held
// bar. No new item is taken until the current one has left ST_DONE, so
// s_tready is high only while no item is in work.
//
// The output register keeps one result. A new item may be accepted while it
// waits; if the receiver stalls, the next result holds in the final step
// until m_tready frees the register. Reset clears the held bar, the count and
// any pending result, and sets the bar length to one minute.
module ohlc_bid_ask_bar_aggregator_top #(
    parameter int PRICE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ohlc_pkg::MIN_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: in_time, in_bid_open, in_bid_close, in_bid_high,
    // in_bid_low, in_ask_open, in_ask_close, in_ask_high, in_ask_low,
    // in_volume, one zero bit.
    input  logic [ohlc_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata from bit 0: out_count, out_start, out_bid_open, out_bid_close,
    // out_bid_high, out_bid_low, out_ask_open, out_ask_close, out_ask_high,
    // out_ask_low, out_volume, one zero bit.
    output logic [ohlc_pkg::OUT_DATA_W-1:0]   m_tdata,
    // tuser: out_new_bar.
    output logic                              m_tuser
);

    ohlc_pkg::state_t                   state_reg, state_next;
    logic [ohlc_pkg::MIN_W-1:0]         minutes_reg, minutes_next;
    logic [ohlc_pkg::TIME_W-1:0]        time_reg, time_next;
    logic [PRICE_BITS-1:0]              in_price_reg [ohlc_pkg::NUM_PRICES];
    logic [PRICE_BITS-1:0]              in_price_next [ohlc_pkg::NUM_PRICES];
    logic [ohlc_pkg::FIELD_W-1:0]       in_volume_reg, in_volume_next;
    logic [ohlc_pkg::PER_W-1:0]         period_reg, period_next;
    logic [ohlc_pkg::PER_W-1:0]         rem_reg, rem_next;
    logic [ohlc_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                               held_valid_reg, held_valid_next;
    logic [ohlc_pkg::TIME_W-1:0]        held_start_reg, held_start_next;
    logic [PRICE_BITS-1:0]              held_price_reg [ohlc_pkg::NUM_PRICES];
    logic [PRICE_BITS-1:0]              held_price_next [ohlc_pkg::NUM_PRICES];
    logic [ohlc_pkg::FIELD_W-1:0]       held_volume_reg, held_volume_next;
    logic [ohlc_pkg::FIELD_W-1:0]       held_count_reg, held_count_next;
    logic                               out_valid_reg, out_valid_next;
    logic [ohlc_pkg::OUT_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                               out_new_bar_reg, out_new_bar_next;

    logic                               accept;
    logic                               load;
    logic                               opened;
    logic [ohlc_pkg::MIN_W-1:0]         mins;
    logic [ohlc_pkg::PER_W:0]           rem_shift;
    logic                               rem_ge;
    logic [ohlc_pkg::TIME_W-1:0]        bar_start;

    assign s_tready = (state_reg == ohlc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_new_bar_reg;

    // Input capture, with prices cut to the internal price width.
    always_comb
    begin
        logic [PRICE_BITS+ohlc_pkg::FIELD_W-1:0] ext;
        ext = '0;
        time_next      = time_reg;
        in_volume_next = in_volume_reg;
        for (int i = 0; i < ohlc_pkg::NUM_PRICES; i++)
        begin
            in_price_next[i] = in_price_reg[i];
        end
        if (accept)
        begin
            time_next      = s_tdata[ohlc_pkg::TIME_W-1:0];
            in_volume_next = s_tdata[ohlc_pkg::IN_VOL_LSB +: ohlc_pkg::FIELD_W];
            for (int i = 0; i < ohlc_pkg::NUM_PRICES; i++)
            begin
                ext = {{PRICE_BITS{1'b0}},
                       s_tdata[ohlc_pkg::IN_PRICE_LSB + ohlc_pkg::FIELD_W*i
                               +: ohlc_pkg::FIELD_W]};
                in_price_next[i] = ext[PRICE_BITS-1:0];
            end
        end
    end

    // Shared remainder unit: shift in one timestamp bit, subtract if it fits.
    assign mins      = (minutes_reg == '0) ? ohlc_pkg::MIN_W'(1) : minutes_reg;
    assign rem_shift = {rem_reg, time_reg[cnt_reg]};
    assign rem_ge    = (rem_shift >= {1'b0, period_reg});
    assign bar_start = time_reg
                     - {{(ohlc_pkg::TIME_W-ohlc_pkg::PER_W){1'b0}}, rem_reg};
    assign opened    = !held_valid_reg || (bar_start != held_start_reg);
    assign load      = (state_reg == ohlc_pkg::ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        minutes_next = cfg_wr_en ? cfg_wr_data : minutes_reg;
        period_next  = period_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ohlc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ohlc_pkg::ST_PERIOD;
                end
            end
            ohlc_pkg::ST_PERIOD:
            begin
                period_next = ohlc_pkg::PER_W'(mins)
                            * ohlc_pkg::PER_W'(ohlc_pkg::NS_PER_MINUTE);
                rem_next    = '0;
                cnt_next    = ohlc_pkg::CNT_W'(ohlc_pkg::TIME_W - 1);
                state_next  = ohlc_pkg::ST_DIV;
            end
            ohlc_pkg::ST_DIV:
            begin
                rem_next = rem_ge ? rem_shift[ohlc_pkg::PER_W-1:0]
                                    - period_reg
                                  : rem_shift[ohlc_pkg::PER_W-1:0];
                cnt_next = cnt_reg - ohlc_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ohlc_pkg::ST_DONE;
                end
            end
            ohlc_pkg::ST_DONE:
            begin
                if (load)
                begin
                    state_next = ohlc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ohlc_pkg::ST_IDLE;
            end
        endcase
    end

    // Merge into the held bar and pack the result.
    always_comb
    begin
        logic [PRICE_BITS+ohlc_pkg::FIELD_W-1:0] ext;
        logic [ohlc_pkg::FIELD_W-1:0]            price_out [ohlc_pkg::NUM_PRICES];
        ext              = '0;
        held_valid_next  = held_valid_reg;
        held_start_next  = held_start_reg;
        held_volume_next = held_volume_reg;
        held_count_next  = held_count_reg;
        for (int i = 0; i < ohlc_pkg::NUM_PRICES; i++)
        begin
            held_price_next[i] = held_price_reg[i];
        end
        if (load)
        begin
            if (opened)
            begin
                held_valid_next  = 1'b1;
                held_start_next  = bar_start;
                held_volume_next = in_volume_reg;
                held_count_next  = held_count_reg + ohlc_pkg::FIELD_W'(1);
                for (int i = 0; i < ohlc_pkg::NUM_PRICES; i++)
                begin
                    held_price_next[i] = in_price_reg[i];
                end
            end
            else
            begin
                if (in_price_reg[ohlc_pkg::P_BH] > held_price_reg[ohlc_pkg::P_BH])
                begin
                    held_price_next[ohlc_pkg::P_BH] = in_price_reg[ohlc_pkg::P_BH];
                end
                if (in_price_reg[ohlc_pkg::P_BL] < held_price_reg[ohlc_pkg::P_BL])
                begin
                    held_price_next[ohlc_pkg::P_BL] = in_price_reg[ohlc_pkg::P_BL];
                end
                if (in_price_reg[ohlc_pkg::P_AH] > held_price_reg[ohlc_pkg::P_AH])
                begin
                    held_price_next[ohlc_pkg::P_AH] = in_price_reg[ohlc_pkg::P_AH];
                end
                if (in_price_reg[ohlc_pkg::P_AL] < held_price_reg[ohlc_pkg::P_AL])
                begin
                    held_price_next[ohlc_pkg::P_AL] = in_price_reg[ohlc_pkg::P_AL];
                end
                held_price_next[ohlc_pkg::P_BC] = in_price_reg[ohlc_pkg::P_BC];
                held_price_next[ohlc_pkg::P_AC] = in_price_reg[ohlc_pkg::P_AC];
            end
        end
        for (int i = 0; i < ohlc_pkg::NUM_PRICES; i++)
        begin
            ext          = {{ohlc_pkg::FIELD_W{1'b0}}, held_price_next[i]};
            price_out[i] = ext[ohlc_pkg::FIELD_W-1:0];
        end
        out_new_bar_next = load ? opened : out_new_bar_reg;
        out_data_next    = load ? {1'b0, held_volume_next,
                                   price_out[ohlc_pkg::P_AL], price_out[ohlc_pkg::P_AH],
                                   price_out[ohlc_pkg::P_AC], price_out[ohlc_pkg::P_AO],
                                   price_out[ohlc_pkg::P_BL], price_out[ohlc_pkg::P_BH],
                                   price_out[ohlc_pkg::P_BC], price_out[ohlc_pkg::P_BO],
                                   held_start_next, held_count_next}
                                : out_data_reg;
        out_valid_next   = load || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ohlc_pkg::ST_IDLE;
            minutes_reg    <= ohlc_pkg::MIN_W'(1);
            held_valid_reg <= 1'b0;
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            minutes_reg    <= minutes_next;
            held_valid_reg <= held_valid_next;
            held_count_reg <= held_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg        <= time_next;
        in_volume_reg   <= in_volume_next;
        period_reg      <= period_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        held_start_reg  <= held_start_next;
        held_volume_reg <= held_volume_next;
        out_data_reg    <= out_data_next;
        out_new_bar_reg <= out_new_bar_next;
        for (int i = 0; i < ohlc_pkg::NUM_PRICES; i++)
        begin
            in_price_reg[i]   <= in_price_next[i];
            held_price_reg[i] <= held_price_next[i];
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ohlc_pkg::ST_PERIOD)
        else $error("accepted item did not start the period step");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ohlc_pkg::ST_DIV |-> rem_reg < period_reg)
        else $error("partial remainder reached the period");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && opened) |=> held_count_reg == $past(held_count_reg) + 32'd1)
        else $error("bar count did not advance on a new bar");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ohlc_pkg::ST_DONE))
        else $error("result raised outside the final step");

endmodule
